// ===== rtl/rwf_pkg.sv =====
// Shared types and constants for the replay window filter.
package rwf_pkg;

  // Field widths.
  localparam int SEQ_W = 64;
  localparam int MAP_W = 64;
  localparam int OUT_TDATA_W = 8;

  // Window size; the usable window is limited by the width of the map.
  localparam int WINDOW_BITS = 64;
  localparam int EFF_WIN = (WINDOW_BITS > MAP_W) ? MAP_W : WINDOW_BITS;
  localparam int AGE_W = $clog2(MAP_W);
  localparam logic [SEQ_W-1:0] EFF_WIN_SEQ = SEQ_W'(EFF_WIN);
  localparam logic [MAP_W-1:0] MAP_ONE = MAP_W'(1);
  localparam logic [MAP_W-1:0] WIN_MASK =
    (EFF_WIN >= MAP_W) ? {MAP_W{1'b1}} : ((MAP_ONE << EFF_WIN) - MAP_ONE);

  // Request kinds.
  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_MARK  = 1'b1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic             mark;
    logic [SEQ_W-1:0] seq;
  } rwf_item_t;

endpackage

// ===== rtl/replay_window_filter.sv =====
// Top level of the replay window filter: front queue and back window unit.
//
// Anti-replay window for 64-bit record sequence numbers. Each request carries a
// sequence number on s_axis_tdata and a kind on s_axis_tuser (0 checks, 1 marks
// the record as received); each request yields exactly one result with the
// accepted and is_newer flags. The block takes one request per clock cycle
// when the result side keeps up; a taken request passes through the
// two-entry front queue and then the result register before its result
// appears. The throughput is set by the window update in the back end, which
// compares, shifts and writes the 64-bit map and highest number together so
// that each request sees the state left by the one before it. No clearing
// pass is needed after reset.
module replay_window_filter
  import rwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SEQ_W-1:0]       s_axis_tdata,   // [63:0] seq_num
  input  logic                   s_axis_tuser,   // [0] kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] accepted, [1] is_newer, [7:2] zero
);

  logic      item_valid;
  logic      item_ready;
  rwf_item_t item;

  // Front end: accept and classify requests.
  rwf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready)
  );

  // Back end: check against the window and update it.
  rwf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/rwf_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module rwf_front
  import rwf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [SEQ_W-1:0] s_axis_tdata,   // [63:0] seq_num
  input  logic             s_axis_tuser,   // [0] kind
  output logic             item_valid,
  output rwf_item_t        item,
  input  logic             item_ready
);

  rwf_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  rwf_item_t          in_item;

  // Classify the incoming request.
  always_comb begin
    in_item.mark = (s_axis_tuser == KIND_MARK);
    in_item.seq  = s_axis_tdata;
  end

  assign s_axis_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push = s_axis_tvalid && s_axis_tready;
  assign item_valid = (count != '0);
  assign pop = item_valid && item_ready;
  assign item = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rwf_back.sv =====
// Back end: window state, check and update, and the result register.
module rwf_back
  import rwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  rwf_item_t              item,
  output logic                   item_ready,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] accepted, [1] is_newer, [7:2] zero
);

  logic [SEQ_W-1:0] highest_seq;
  logic [MAP_W-1:0] seen_map;
  logic [SEQ_W-1:0] highest_seq_next;
  logic [MAP_W-1:0] seen_map_next;
  logic             out_accepted;
  logic             out_newer;

  logic             take;
  logic [SEQ_W-1:0] fwd;
  logic [SEQ_W-1:0] neg;
  logic             behind;
  logic             newer;
  logic             fwd_in_win;
  logic             age_in_win;
  logic [AGE_W-1:0] age;
  logic             ok;

  assign item_ready = !m_axis_tvalid || m_axis_tready;
  assign take = item_valid && item_ready;

  // Distance from the highest number, in both directions.
  always_comb begin
    fwd        = item.seq - highest_seq;
    neg        = highest_seq - item.seq;
    behind     = (item.seq < highest_seq);
    newer      = !behind && (fwd != '0);
    fwd_in_win = (fwd < EFF_WIN_SEQ);
    age_in_win = !behind || (neg < EFF_WIN_SEQ);
    age        = behind ? neg[AGE_W-1:0] : '0;
    ok         = newer || (age_in_win && !seen_map[age]);
  end

  // Window update for a mark request.
  always_comb begin
    highest_seq_next = highest_seq;
    seen_map_next    = seen_map;
    if (take && item.mark) begin
      if (newer) begin
        highest_seq_next = item.seq;
        if (fwd_in_win) begin
          seen_map_next = ((seen_map << fwd[AGE_W-1:0]) | MAP_ONE) & WIN_MASK;
        end else begin
          seen_map_next = MAP_ONE;
        end
      end else if (age_in_win) begin
        seen_map_next = seen_map | (MAP_ONE << age);
      end
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      highest_seq   <= '0;
      seen_map      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      highest_seq <= highest_seq_next;
      seen_map    <= seen_map_next;
      if (take) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_accepted <= ok;
      out_newer    <= newer;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - 2){1'b0}}, out_newer, out_accepted};

`ifndef ASSERT_OFF
  // Map bits beyond the window never get set.
  a_map_in_window: assert property (@(posedge clk) disable iff (rst)
    (seen_map & ~WIN_MASK) == '0)
    else $error("seen_map has bits outside the window");

  // The highest number never moves backward.
  a_highest_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (highest_seq >= $past(highest_seq)))
    else $error("highest_seq decreased");

  // A newer mark becomes the highest number with its own bit set.
  a_newer_mark: assert property (@(posedge clk) disable iff (rst)
    (take && item.mark && newer) |=>
      (seen_map[0] && (highest_seq == $past(item.seq))))
    else $error("newer mark did not advance the window");

  // A newer number is always accepted.
  a_newer_accepted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_newer) |-> out_accepted)
    else $error("newer result not accepted");
`endif

endmodule
